@@ rtl/core/hkre_pkg.sv @@
// ----------------------------------------------------------------------------
// hkre_pkg
// Shared types and constants for the boot-keyboard key event extractor.
// ----------------------------------------------------------------------------
package hkre_pkg;

  localparam int KeySlots  = 6;
  localparam int CodeW     = 8;
  localparam int SlotIdxW  = $clog2(KeySlots);
  localparam int ModW      = 8;

  localparam logic [CodeW-1:0] BackspaceCode = 8'h2A;
  localparam int ShiftLeftBit  = 1;
  localparam int ShiftRightBit = 5;

  typedef logic [KeySlots-1:0][CodeW-1:0] codes_t;

  typedef enum logic {
    ItemPress  = 1'b0,
    ItemStatus = 1'b1
  } item_kind_e;

  // Result of comparing one report with the previous one
  typedef struct packed {
    logic [KeySlots-1:0] press_mask;  // new codes that emit a press item
    logic                any_pressed;
    logic                any_released;
    logic                shift;
  } diff_t;

endpackage

@@ rtl/core/hid_keyboard_report_key_events.sv @@
// ----------------------------------------------------------------------------
// hid_keyboard_report_key_events
// Turns boot-keyboard reports into key press items and a status item.
//
//   channel | direction | signals
//   --------+-----------+-----------------------------------------------
//   in      | request   | in_valid_i/in_ready_o, modifiers_i, key_slot_*_i
//   out     | result    | out_valid_o/out_ready_i, item_kind_o .. last_of_report_o
//
// A report gives a press item per new key (Backspace aside) plus a status item,
// so 1 to 7 items; the single output register sends one per cycle if not stalled.
// The input register takes the next report while the current one drains.
// Reset clears all valid flags and the previous-report codes (no keys held).
// A stalled output holds its item; the input stalls once both stages fill.
// ----------------------------------------------------------------------------
module hid_keyboard_report_key_events
  import hkre_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ModW-1:0]  modifiers_i,
  input  logic [CodeW-1:0] key_slot_0_i,
  input  logic [CodeW-1:0] key_slot_1_i,
  input  logic [CodeW-1:0] key_slot_2_i,
  input  logic [CodeW-1:0] key_slot_3_i,
  input  logic [CodeW-1:0] key_slot_4_i,
  input  logic [CodeW-1:0] key_slot_5_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             item_kind_o,
  output logic [CodeW-1:0] pressed_code_o,
  output logic             shift_held_o,
  output logic             any_pressed_o,
  output logic             any_released_o,
  output logic             last_of_report_o
);

  logic            a_valid_q, a_valid_d;
  logic [ModW-1:0] a_mods_q;
  codes_t          a_codes_q;
  codes_t          prev_q;
  codes_t          in_codes;
  diff_t           diff;
  logic            a_xfer;
  logic            ld_ready;
  logic            in_take;
  item_kind_e      out_kind;

  assign in_codes = {key_slot_5_i, key_slot_4_i, key_slot_3_i,
                     key_slot_2_i, key_slot_1_i, key_slot_0_i};

  assign a_xfer     = a_valid_q && ld_ready;
  assign in_ready_o = !a_valid_q || a_xfer;
  assign in_take    = in_valid_i && in_ready_o;

  // Input register
  always_comb begin
    a_valid_d = a_valid_q;
    if (in_take) begin
      a_valid_d = 1'b1;
    end else if (a_xfer) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      a_mods_q  <= modifiers_i;
      a_codes_q <= in_codes;
    end
  end

  // Previous report codes, replaced as each report moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (a_xfer) begin
      prev_q <= a_codes_q;
    end
  end

  hkre_diff u_diff (
    .cur_i  (a_codes_q),
    .prev_i (prev_q),
    .mods_i (a_mods_q),
    .diff_o (diff)
  );

  hkre_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ld_valid_i     (a_valid_q),
    .ld_ready_o     (ld_ready),
    .ld_codes_i     (a_codes_q),
    .ld_diff_i      (diff),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_kind_o     (out_kind),
    .out_code_o     (pressed_code_o),
    .out_shift_o    (shift_held_o),
    .out_pressed_o  (any_pressed_o),
    .out_released_o (any_released_o),
    .out_last_o     (last_of_report_o)
  );

  assign item_kind_o = out_kind;

`ifndef SYNTHESIS
  // Press items carry a real code and no summary flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind == ItemPress) |->
      (pressed_code_o != '0) && (pressed_code_o != BackspaceCode) &&
      !any_pressed_o && !any_released_o && !last_of_report_o)
    else $error("press item with bad code or flags");

  // A status item closes the report and carries no code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind == ItemStatus) |->
      last_of_report_o && (pressed_code_o == '0))
    else $error("status item malformed");

  // A press item reports a new key, so its status must flag a press
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && (out_kind == ItemPress) |=>
      !out_valid_o || (out_kind == ItemPress) || any_pressed_o)
    else $error("status after press item lacks any_pressed");

  // History only moves when a report enters the emitter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !a_xfer |=> $stable(prev_q))
    else $error("previous codes changed without a transfer");
`endif

endmodule

@@ rtl/core/hkre_diff.sv @@
// ----------------------------------------------------------------------------
// hkre_diff
// Compares the current report against the stored codes of the previous one.
// ----------------------------------------------------------------------------
module hkre_diff
  import hkre_pkg::*;
(
  input  codes_t          cur_i,
  input  codes_t          prev_i,
  input  logic [ModW-1:0] mods_i,
  output diff_t           diff_o
);

  logic [KeySlots-1:0] new_mask;
  logic [KeySlots-1:0] gone_mask;

  // Per-slot membership checks, both directions
  always_comb begin
    new_mask  = '0;
    gone_mask = '0;
    for (int i = 0; i < KeySlots; i++) begin
      new_mask[i]  = (cur_i[i] != '0);
      gone_mask[i] = (prev_i[i] != '0);
      for (int j = 0; j < KeySlots; j++) begin
        if (cur_i[i] == prev_i[j]) begin
          new_mask[i] = 1'b0;
        end
        if (prev_i[i] == cur_i[j]) begin
          gone_mask[i] = 1'b0;
        end
      end
    end
  end

  // Backspace still counts as a press but emits no item
  always_comb begin
    for (int i = 0; i < KeySlots; i++) begin
      diff_o.press_mask[i] = new_mask[i] && (cur_i[i] != BackspaceCode);
    end
    diff_o.any_pressed  = |new_mask;
    diff_o.any_released = |gone_mask;
    diff_o.shift        = mods_i[ShiftLeftBit] | mods_i[ShiftRightBit];
  end

endmodule

@@ rtl/core/hkre_emit.sv @@
// ----------------------------------------------------------------------------
// hkre_emit
// Holds one compared report and sends its press items, then its status
// item, through the output register one per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module hkre_emit
  import hkre_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // load side
  input  logic             ld_valid_i,
  output logic             ld_ready_o,
  input  codes_t           ld_codes_i,
  input  diff_t            ld_diff_i,
  // result side
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output item_kind_e       out_kind_o,
  output logic [CodeW-1:0] out_code_o,
  output logic             out_shift_o,
  output logic             out_pressed_o,
  output logic             out_released_o,
  output logic             out_last_o
);

  logic                b_valid_q, b_valid_d;
  logic [KeySlots-1:0] b_mask_q, b_mask_d;
  codes_t              b_codes_q;
  diff_t               b_diff_q;

  logic             out_valid_q, out_valid_d;
  item_kind_e       out_kind_q;
  logic [CodeW-1:0] out_code_q;
  logic             out_shift_q, out_pressed_q, out_released_q;

  logic                out_load;
  logic                has_press;
  logic [SlotIdxW-1:0] sel_idx;
  logic                ld_take;

  // Lowest pending slot goes first
  always_comb begin
    sel_idx = '0;
    for (int i = KeySlots - 1; i >= 0; i--) begin
      if (b_mask_q[i]) begin
        sel_idx = SlotIdxW'(i);
      end
    end
  end

  assign has_press  = |b_mask_q;
  assign out_load   = b_valid_q && (!out_valid_q || out_ready_i);
  assign ld_ready_o = !b_valid_q || (out_load && !has_press);
  assign ld_take    = ld_valid_i && ld_ready_o;

  // Report holding stage
  always_comb begin
    b_valid_d = b_valid_q;
    b_mask_d  = b_mask_q;
    if (out_load) begin
      if (has_press) begin
        b_mask_d[sel_idx] = 1'b0;
      end else begin
        b_valid_d = 1'b0;
      end
    end
    if (ld_take) begin
      b_valid_d = 1'b1;
      b_mask_d  = ld_diff_i.press_mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      b_mask_q  <= '0;
    end else begin
      b_valid_q <= b_valid_d;
      b_mask_q  <= b_mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_take) begin
      b_codes_q <= ld_codes_i;
      b_diff_q  <= ld_diff_i;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_shift_q <= b_diff_q.shift;
      if (has_press) begin
        out_kind_q     <= ItemPress;
        out_code_q     <= b_codes_q[sel_idx];
        out_pressed_q  <= 1'b0;
        out_released_q <= 1'b0;
      end else begin
        out_kind_q     <= ItemStatus;
        out_code_q     <= '0;
        out_pressed_q  <= b_diff_q.any_pressed;
        out_released_q <= b_diff_q.any_released;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_kind_o     = out_kind_q;
  assign out_code_o     = out_code_q;
  assign out_shift_o    = out_shift_q;
  assign out_pressed_o  = out_pressed_q;
  assign out_released_o = out_released_q;
  assign out_last_o     = (out_kind_q == ItemStatus);

endmodule
